// File: hw/rtl/srnt_pkg.sv
// shared types, codes and helpers for the scsi read to nvme translator
package srnt_pkg;

    localparam int unsigned BLOCK_SIZE_W = 17;
    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 17'd512;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_BLOCK_SIZE = 3'd0;

    localparam logic [1:0] OP_READ6  = 2'd0;
    localparam logic [1:0] OP_READ10 = 2'd1;
    localparam logic [1:0] OP_READ12 = 2'd2;
    localparam logic [1:0] OP_READ16 = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_NOTRANS = 2'd3;

    localparam logic [8:0] READ6_ZERO_LEN = 9'd256;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] cdb_head;
        logic [63:0] cdb_tail;
        logic [31:0] namespace_id;
        logic [63:0] buffer_address;
        logic [31:0] buffer_bytes;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] cmd_dword10;
        logic [31:0] cmd_dword11;
        logic [31:0] cmd_dword12;
        logic [31:0] cmd_namespace;
        logic [63:0] prp_entry_one;
        logic [31:0] data_length;
    } rsp_t;

    // decoded command between the decode and assemble stages
    typedef struct packed {
        logic [1:0]  opcode;
        logic        early_err;
        logic [1:0]  early_status;
        logic [63:0] lba;
        logic [15:0] len_m1;
        logic [2:0]  rdprotect;
        logic        fua;
        logic [31:0] byte_len;
        logic [31:0] namespace_id;
        logic [63:0] buffer_address;
        logic [31:0] buffer_bytes;
    } mid_t;

    // {translatable, prinfo}
    function automatic logic [4:0] prinfo_of(input logic [2:0] rdp);
        logic [4:0] r;
        case (rdp)
            3'd0:    r = 5'b1_1111;
            3'd1:    r = 5'b1_0111;
            3'd2:    r = 5'b1_0011;
            3'd3:    r = 5'b1_0000;
            3'd4:    r = 5'b1_0100;
            3'd5:    r = 5'b1_0111;
            default: r = 5'b0_0000;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/srnt_cfg.sv
// apb register block holding the logical block size
module srnt_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [srnt_pkg::PADDR_W-1:0]          paddr,
    input  logic [srnt_pkg::PDATA_W-1:0]          pwdata,
    output logic [srnt_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready,
    output logic [srnt_pkg::BLOCK_SIZE_W-1:0]     block_size
);

    logic [srnt_pkg::BLOCK_SIZE_W-1:0] block_size_reg;
    logic [srnt_pkg::BLOCK_SIZE_W-1:0] block_size_next;
    logic                              hit;

    assign hit    = (paddr == srnt_pkg::REG_BLOCK_SIZE);
    assign pready = 1'b1;

    always_comb
    begin
        block_size_next = block_size_reg;
        if (psel && penable && pwrite && hit)
        begin
            block_size_next = pwdata[srnt_pkg::BLOCK_SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= srnt_pkg::BLOCK_SIZE_RESET;
        end
        else
        begin
            block_size_reg <= block_size_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {{(srnt_pkg::PDATA_W-srnt_pkg::BLOCK_SIZE_W){1'b0}}, block_size_reg};
        end
    end

    assign block_size = block_size_reg;

endmodule

// File: hw/rtl/srnt_decode.sv
// cdb field extraction, range checks and byte length product
module srnt_decode (
    input  srnt_pkg::req_t                        req,
    input  logic [srnt_pkg::BLOCK_SIZE_W-1:0]     block_size,
    output srnt_pkg::mid_t                        mid
);

    logic [31:0] len32;
    logic [16:0] len17;
    logic [33:0] product;
    logic [7:0]  byte1;

    assign byte1 = req.cdb_head[55:48];

    always_comb
    begin
        mid                = '0;
        mid.opcode         = req.opcode;
        mid.namespace_id   = req.namespace_id;
        mid.buffer_address = req.buffer_address;
        mid.buffer_bytes   = req.buffer_bytes;
        len32              = '0;
        case (req.opcode)
            srnt_pkg::OP_READ6:
            begin
                mid.lba = {43'd0, req.cdb_head[52:32]};
                len32   = {24'd0, req.cdb_head[31:24]};
                if (req.cdb_head[31:24] == 8'd0)
                begin
                    len32 = {23'd0, srnt_pkg::READ6_ZERO_LEN};
                end
            end
            srnt_pkg::OP_READ10:
            begin
                mid.lba = {32'd0, req.cdb_head[47:16]};
                len32   = {16'd0, req.cdb_head[7:0], req.cdb_tail[63:56]};
            end
            srnt_pkg::OP_READ12:
            begin
                mid.lba = {32'd0, req.cdb_head[47:16]};
                len32   = {req.cdb_head[15:0], req.cdb_tail[63:48]};
            end
            default:
            begin
                mid.lba = {req.cdb_head[47:0], req.cdb_tail[63:48]};
                len32   = req.cdb_tail[47:16];
            end
        endcase

        if (req.opcode != srnt_pkg::OP_READ6)
        begin
            mid.rdprotect = byte1[7:5];
            mid.fua       = byte1[3];
            if (len32 == 32'd0)
            begin
                mid.early_err    = 1'b1;
                mid.early_status = srnt_pkg::ST_NOTRANS;
            end
            else if (len32[31:16] != 16'd0)
            begin
                mid.early_err    = 1'b1;
                mid.early_status = srnt_pkg::ST_INVALID;
            end
        end

        len17        = len32[16:0];
        product      = len17 * block_size;
        mid.len_m1   = len17[15:0] - 16'd1;
        mid.byte_len = product[31:0];
    end

endmodule

// File: hw/rtl/srnt_assemble.sv
// buffer check, rdprotect mapping and nvme command build
module srnt_assemble (
    input  srnt_pkg::mid_t mid,
    output srnt_pkg::rsp_t rsp
);

    logic [4:0] pi;

    assign pi = srnt_pkg::prinfo_of(mid.rdprotect);

    always_comb
    begin
        rsp = '0;
        if (mid.early_err)
        begin
            rsp.status = mid.early_status;
        end
        else if (mid.buffer_bytes < mid.byte_len)
        begin
            rsp.status      = srnt_pkg::ST_SHORT;
            rsp.data_length = mid.byte_len;
        end
        else if ((mid.opcode != srnt_pkg::OP_READ6) && !pi[4])
        begin
            rsp.status      = srnt_pkg::ST_INVALID;
            rsp.data_length = mid.byte_len;
        end
        else
        begin
            rsp.status        = srnt_pkg::ST_OK;
            rsp.cmd_dword10   = mid.lba[31:0];
            rsp.cmd_dword11   = (mid.opcode == srnt_pkg::OP_READ16) ? mid.lba[63:32] : 32'd0;
            rsp.cmd_dword12   = {16'd0, mid.len_m1};
            if (mid.opcode != srnt_pkg::OP_READ6)
            begin
                rsp.cmd_dword12[30]    = mid.fua;
                rsp.cmd_dword12[29:26] = pi[3:0];
            end
            rsp.cmd_namespace = mid.namespace_id;
            rsp.prp_entry_one = mid.buffer_address;
            rsp.data_length   = mid.byte_len;
        end
    end

endmodule

// File: hw/rtl/scsi_read_to_nvme_translate.sv
// top level of the scsi read cdb to nvme read command translator
//
// req carries one scsi read(6/10/12/16) cdb with namespace id and host
// buffer; rsp carries the nvme read dwords 10 to 12, namespace, prp1,
// byte length and a status code, exactly one rsp beat per req beat.
// a beat moves at a clock edge where valid is high and stall is low.
// the apb port holds the logical block size (reset 512) at address 0;
// write it only while no beats are in flight.
// three register stages: input capture, decode plus length multiply,
// buffer check and command build; one beat per cycle is sustained
// while rsp is not stalled. the 17 by 17 length multiply in the
// middle stage sets the cycle time.
// when rsp is stalled the stages fill up and req_stall rises only once
// every stage holds a beat; bubbles are squeezed out meanwhile.
// reset empties all stages and restores the block size; nothing is
// lost or repeated across a stall.
module scsi_read_to_nvme_translate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  srnt_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output srnt_pkg::rsp_t                    rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srnt_pkg::PADDR_W-1:0]      paddr,
    input  logic [srnt_pkg::PDATA_W-1:0]      pwdata,
    output logic [srnt_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    logic [srnt_pkg::BLOCK_SIZE_W-1:0] block_size;

    logic           a_valid_reg;
    logic           b_valid_reg;
    logic           c_valid_reg;
    srnt_pkg::req_t a_reg;
    srnt_pkg::mid_t b_reg;
    srnt_pkg::rsp_t c_reg;
    srnt_pkg::mid_t b_next;
    srnt_pkg::rsp_t c_next;
    logic           a_adv;
    logic           b_adv;
    logic           c_adv;

    srnt_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .block_size (block_size)
    );

    srnt_decode u_decode (
        .req        (a_reg),
        .block_size (block_size),
        .mid        (b_next)
    );

    srnt_assemble u_assemble (
        .mid (b_reg),
        .rsp (c_next)
    );

    assign c_adv     = !c_valid_reg || !rsp_stall;
    assign b_adv     = !b_valid_reg || c_adv;
    assign a_adv     = !a_valid_reg || b_adv;
    assign req_stall = !a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= req_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_adv)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && req_valid)
        begin
            a_reg <= req;
        end
        if (b_adv && a_valid_reg)
        begin
            b_reg <= b_next;
        end
        if (c_adv && b_valid_reg)
        begin
            c_reg <= c_next;
        end
    end

    assign rsp_valid = c_valid_reg;
    assign rsp       = c_reg;

endmodule
